[rtl/fgbb_pkg.sv]
// Package for the foreground bounding box block.
// Holds the format codes, dimension widths and the result word type.
// No dependencies.
`default_nettype none

package fgbb_pkg;

  // largest frame dimension in pixels
  localparam int MAX_DIM = 256;

  // position counters run 0 .. MAX_DIM-1
  localparam int CNT_W = (MAX_DIM > 2) ? $clog2(MAX_DIM) : 1;
  // effective dimension runs 1 .. MAX_DIM
  localparam int DIM_W = $clog2(MAX_DIM + 1);
  // compare width for counter + 1 against a dimension
  localparam int CMP_W = (DIM_W > CNT_W + 1) ? DIM_W : CNT_W + 1;

  localparam int FMT_W     = 3;
  localparam int DIM_CFG_W = 9;
  localparam int COLOR_W   = 24;
  localparam int PIXEL_W   = 32;
  localparam int BOX_W     = 8;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = 24;

  // pixel format codes
  localparam logic [FMT_W-1:0] FMT_555 = 3'd0;
  localparam logic [FMT_W-1:0] FMT_565 = 3'd1;
  localparam logic [FMT_W-1:0] FMT_24  = 3'd2;
  localparam logic [FMT_W-1:0] FMT_32  = 3'd3;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_PIXEL_FORMAT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_BACK_COLOR   = 2'd3;

  typedef struct packed {
    logic             found;
    logic [BOX_W-1:0] left;
    logic [BOX_W-1:0] top;
    logic [BOX_W-1:0] right;
    logic [BOX_W-1:0] bottom;
  } box_t;

endpackage

`default_nettype wire

[rtl/fgbb_decode.sv]
// Pixel decode and background compare for the foreground bounding box block.
// Depends on fgbb_pkg.
`default_nettype none

module fgbb_decode (
  input  wire logic [fgbb_pkg::PIXEL_W-1:0] pixel_word,
  input  wire logic [fgbb_pkg::FMT_W-1:0]   pixel_format,
  input  wire logic [fgbb_pkg::COLOR_W-1:0] back_color,
  output logic                              fg
);

  logic [15:0]                    v;
  logic [fgbb_pkg::COLOR_W-1:0]   color;

  assign v = pixel_word[15:0];

  always_comb begin
    case (pixel_format)
      fgbb_pkg::FMT_555: begin
        color = {v[14:10], 3'b000, v[9:5], 3'b000, v[4:0], 3'b000};
      end
      fgbb_pkg::FMT_565: begin
        color = {v[15:11], 3'b000, v[10:5], 2'b00, v[4:0], 3'b000};
      end
      fgbb_pkg::FMT_24, fgbb_pkg::FMT_32: begin
        // swap byte order: byte 0 lands in the top of the colour
        color = {pixel_word[7:0], pixel_word[15:8], pixel_word[23:16]};
      end
      default: begin
        color = '0;
      end
    endcase
  end

  assign fg = (color != back_color);

endmodule

`default_nettype wire

[rtl/fgbb_tracker.sv]
// Position counters and min / max trackers for the foreground bounding box.
// Gives the frame-end flag and the result word for the pixel in hand.
// Depends on fgbb_pkg.
`default_nettype none

module fgbb_tracker (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              advance,
  input  wire logic                              fg,
  input  wire logic [fgbb_pkg::DIM_CFG_W-1:0]    frame_width,
  input  wire logic [fgbb_pkg::DIM_CFG_W-1:0]    frame_height,
  output logic                                   last,
  output fgbb_pkg::box_t                         box
);

  logic [fgbb_pkg::CNT_W-1:0] col_count;
  logic [fgbb_pkg::CNT_W-1:0] row_count;
  logic [fgbb_pkg::CNT_W-1:0] min_col;
  logic [fgbb_pkg::CNT_W-1:0] max_col;
  logic [fgbb_pkg::CNT_W-1:0] min_row;
  logic [fgbb_pkg::CNT_W-1:0] max_row;
  logic                       any_found;

  logic [fgbb_pkg::CNT_W-1:0] min_col_next;
  logic [fgbb_pkg::CNT_W-1:0] max_col_next;
  logic [fgbb_pkg::CNT_W-1:0] min_row_next;
  logic [fgbb_pkg::CNT_W-1:0] max_row_next;
  logic                       any_found_next;

  logic [fgbb_pkg::DIM_W-1:0] eff_w;
  logic [fgbb_pkg::DIM_W-1:0] eff_h;
  logic [fgbb_pkg::CMP_W-1:0] col_inc;
  logic [fgbb_pkg::CMP_W-1:0] row_inc;
  logic                       row_end;

  // zero acts as one, oversize saturates
  always_comb begin
    if (frame_width == '0) begin
      eff_w = fgbb_pkg::DIM_W'(1);
    end else if (32'(frame_width) > fgbb_pkg::MAX_DIM) begin
      eff_w = fgbb_pkg::DIM_W'(fgbb_pkg::MAX_DIM);
    end else begin
      eff_w = fgbb_pkg::DIM_W'(frame_width);
    end
    if (frame_height == '0) begin
      eff_h = fgbb_pkg::DIM_W'(1);
    end else if (32'(frame_height) > fgbb_pkg::MAX_DIM) begin
      eff_h = fgbb_pkg::DIM_W'(fgbb_pkg::MAX_DIM);
    end else begin
      eff_h = fgbb_pkg::DIM_W'(frame_height);
    end
  end

  assign col_inc = fgbb_pkg::CMP_W'(col_count) + fgbb_pkg::CMP_W'(1);
  assign row_inc = fgbb_pkg::CMP_W'(row_count) + fgbb_pkg::CMP_W'(1);
  assign row_end = (col_inc >= fgbb_pkg::CMP_W'(eff_w));
  assign last    = row_end && (row_inc >= fgbb_pkg::CMP_W'(eff_h));

  // fold the current pixel into the trackers; the first hit takes its own place
  always_comb begin
    min_col_next   = min_col;
    max_col_next   = max_col;
    min_row_next   = min_row;
    max_row_next   = max_row;
    any_found_next = any_found;
    if (fg) begin
      if (!any_found || (col_count < min_col)) min_col_next = col_count;
      if (!any_found || (col_count > max_col)) max_col_next = col_count;
      if (!any_found || (row_count < min_row)) min_row_next = row_count;
      if (!any_found || (row_count > max_row)) max_row_next = row_count;
      any_found_next = 1'b1;
    end
  end

  always_comb begin
    box.found  = any_found_next;
    box.left   = any_found_next ? fgbb_pkg::BOX_W'(min_col_next) : '0;
    box.top    = any_found_next ? fgbb_pkg::BOX_W'(min_row_next) : '0;
    box.right  = any_found_next ? fgbb_pkg::BOX_W'(max_col_next) : '0;
    box.bottom = any_found_next ? fgbb_pkg::BOX_W'(max_row_next) : '0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      col_count <= '0;
      row_count <= '0;
      min_col   <= '1;
      max_col   <= '0;
      min_row   <= '1;
      max_row   <= '0;
      any_found <= 1'b0;
    end else if (advance) begin
      if (last) begin
        // frame done: clear for the next one
        col_count <= '0;
        row_count <= '0;
        min_col   <= '1;
        max_col   <= '0;
        min_row   <= '1;
        max_row   <= '0;
        any_found <= 1'b0;
      end else begin
        if (row_end) begin
          col_count <= '0;
          row_count <= fgbb_pkg::CNT_W'(row_inc);
        end else begin
          col_count <= fgbb_pkg::CNT_W'(col_inc);
        end
        min_col   <= min_col_next;
        max_col   <= max_col_next;
        min_row   <= min_row_next;
        max_row   <= max_row_next;
        any_found <= any_found_next;
      end
    end
  end

endmodule

`default_nettype wire

[rtl/foreground_bounding_box.sv]
// Foreground bounding box over a raster-ordered frame: top level.
// Input register, decode, trackers and the result register.
// Depends on fgbb_pkg, fgbb_decode and fgbb_tracker.
// Throughput: one pixel word per cycle; the input stalls only while the last
// pixel of a frame waits for the result register to be taken.
// The result is registered: the last pixel passes the input register, then its
// box is loaded into the result register once any previous result is taken.
// Reset (rst, synchronous): registers to their reset values, trackers cleared.
`default_nettype none

module foreground_bounding_box (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire logic                               in_valid,
  output logic                                    in_ready,
  input  wire logic [fgbb_pkg::PIXEL_W-1:0]       pixel_word,
  output logic                                    out_valid,
  input  wire logic                               out_ready,
  output logic                                    found,
  output logic [fgbb_pkg::BOX_W-1:0]              box_left,
  output logic [fgbb_pkg::BOX_W-1:0]              box_top,
  output logic [fgbb_pkg::BOX_W-1:0]              box_right,
  output logic [fgbb_pkg::BOX_W-1:0]              box_bottom,
  input  wire logic                               cfg_we,
  input  wire logic [fgbb_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire logic [fgbb_pkg::CFG_DATA_W-1:0]    cfg_data
);

  logic [fgbb_pkg::FMT_W-1:0]     pixel_format;
  logic [fgbb_pkg::DIM_CFG_W-1:0] frame_width;
  logic [fgbb_pkg::DIM_CFG_W-1:0] frame_height;
  logic [fgbb_pkg::COLOR_W-1:0]   back_color;

  logic                           s1_valid;
  logic [fgbb_pkg::PIXEL_W-1:0]   s1_word;
  logic                           s1_fg;
  logic                           s1_last;
  logic                           advance;
  fgbb_pkg::box_t                 s1_box;
  fgbb_pkg::box_t                 out_box;

  always_ff @(posedge clk) begin
    if (rst) begin
      pixel_format <= fgbb_pkg::FMT_24;
      frame_width  <= fgbb_pkg::DIM_CFG_W'(256);
      frame_height <= fgbb_pkg::DIM_CFG_W'(256);
      back_color   <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        fgbb_pkg::REG_PIXEL_FORMAT: pixel_format <= cfg_data[fgbb_pkg::FMT_W-1:0];
        fgbb_pkg::REG_FRAME_WIDTH:  frame_width  <= cfg_data[fgbb_pkg::DIM_CFG_W-1:0];
        fgbb_pkg::REG_FRAME_HEIGHT: frame_height <= cfg_data[fgbb_pkg::DIM_CFG_W-1:0];
        fgbb_pkg::REG_BACK_COLOR:   back_color   <= cfg_data[fgbb_pkg::COLOR_W-1:0];
        default: ;
      endcase
    end
  end

  // a pixel leaves the input register unless it ends a frame and the result
  // register is still full and not being taken
  assign advance  = s1_valid && (!s1_last || !out_valid || out_ready);
  assign in_ready = !s1_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_word <= pixel_word;
    end
  end

  fgbb_decode u_decode (
    .pixel_word   (s1_word),
    .pixel_format (pixel_format),
    .back_color   (back_color),
    .fg           (s1_fg)
  );

  fgbb_tracker u_tracker (
    .clk          (clk),
    .rst          (rst),
    .advance      (advance),
    .fg           (s1_fg),
    .frame_width  (frame_width),
    .frame_height (frame_height),
    .last         (s1_last),
    .box          (s1_box)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance && s1_last) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && s1_last) begin
      out_box <= s1_box;
    end
  end

  assign found      = out_box.found;
  assign box_left   = out_box.left;
  assign box_top    = out_box.top;
  assign box_right  = out_box.right;
  assign box_bottom = out_box.bottom;

  // empty frame gives an all-zero box
  a_empty_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !found |-> box_left == '0 && box_top == '0 &&
                            box_right == '0 && box_bottom == '0)
    else $error("empty frame result carries a non-zero box");

  // a found box is never inverted
  a_box_order: assert property (@(posedge clk) disable iff (rst)
    out_valid && found |-> box_left <= box_right && box_top <= box_bottom)
    else $error("bounding box edges out of order");

  // hold the frame-end pixel while the result register is full and not taken
  a_last_holds: assert property (@(posedge clk) disable iff (rst)
    s1_valid && s1_last && out_valid && !out_ready |-> !in_ready && !advance)
    else $error("frame-end word advanced over an untaken result");

  // an empty input register always takes a word
  a_empty_ready: assert property (@(posedge clk) disable iff (rst)
    !s1_valid |-> in_ready)
    else $error("input stalled with empty input register");

  // a new result is valid in the cycle after a frame-end pixel advances
  a_result_follows: assert property (@(posedge clk) disable iff (rst)
    advance && s1_last |=> out_valid)
    else $error("frame-end word produced no result");

endmodule

`default_nettype wire

[sim/fgbb_box_checker.sv]
`timescale 1ns / 100ps
// Box checker for foreground_bounding_box: watches the pixel, result and register
// ports, predicts the bounding box of every frame and compares each result word.
// Depends on fgbb_pkg.

module fgbb_box_checker (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  input  logic                          in_ready,
  input  logic [fgbb_pkg::PIXEL_W-1:0]  pixel_word,
  input  logic                          out_valid,
  input  logic                          out_ready,
  input  logic                          found,
  input  logic [fgbb_pkg::BOX_W-1:0]    box_left,
  input  logic [fgbb_pkg::BOX_W-1:0]    box_top,
  input  logic [fgbb_pkg::BOX_W-1:0]    box_right,
  input  logic [fgbb_pkg::BOX_W-1:0]    box_bottom,
  input  logic                          cfg_we,
  input  logic [fgbb_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [fgbb_pkg::CFG_DATA_W-1:0] cfg_data,
  output int                            box_errors,
  output int                            boxes_due
);
  import fgbb_pkg::*;

  logic [FMT_W-1:0]     fmt_q;
  logic [DIM_CFG_W-1:0] width_q;
  logic [DIM_CFG_W-1:0] height_q;
  logic [COLOR_W-1:0]   back_q;

  int col_pos, row_pos;
  int left_edge, right_edge, top_edge, bottom_edge;
  bit seen;
  int err_count = 0;

  box_t box_due[$];

  function automatic logic [COLOR_W-1:0] pixel_color(input logic [FMT_W-1:0] fmt,
                                                     input logic [PIXEL_W-1:0] w);
    case (fmt)
      FMT_555: pixel_color = {w[14:10], 3'b000, w[9:5], 3'b000, w[4:0], 3'b000};
      FMT_565: pixel_color = {w[15:11], 3'b000, w[10:5], 2'b00, w[4:0], 3'b000};
      FMT_24, FMT_32: pixel_color = {w[7:0], w[15:8], w[23:16]};
      default: pixel_color = '0;
    endcase
  endfunction

  // zero acts as one, oversize saturates
  function automatic int span(input logic [DIM_CFG_W-1:0] d);
    if (d == 0) return 1;
    if (d > MAX_DIM) return MAX_DIM;
    return int'(d);
  endfunction

  task automatic clear_frame();
    col_pos = 0;
    row_pos = 0;
    left_edge = MAX_DIM;
    top_edge = MAX_DIM;
    right_edge = 0;
    bottom_edge = 0;
    seen = 0;
  endtask

  always @(posedge clk) begin : watch
    box_t want, got;
    int w, h;
    if (rst) begin
      fmt_q = FMT_24;
      width_q = DIM_CFG_W'(MAX_DIM);
      height_q = DIM_CFG_W'(MAX_DIM);
      back_q = '0;
      clear_frame();
      box_due.delete();
    end else begin
      // compare before predicting, so a stray result never meets a fresh entry
      if (out_valid && out_ready) begin
        got.found = found;
        got.left = box_left;
        got.top = box_top;
        got.right = box_right;
        got.bottom = box_bottom;
        if (box_due.size() == 0) begin
          if (err_count < 10)
            $display("box_check: result word with none due: found=%0d (%0d,%0d)-(%0d,%0d)",
                     got.found, got.left, got.top, got.right, got.bottom);
          err_count++;
        end else begin
          want = box_due.pop_front();
          if (got.found !== want.found || got.left !== want.left || got.top !== want.top ||
              got.right !== want.right || got.bottom !== want.bottom) begin
            if (err_count < 10)
              $display("box_check: expected found=%0d (%0d,%0d)-(%0d,%0d), got found=%0d (%0d,%0d)-(%0d,%0d)",
                       want.found, want.left, want.top, want.right, want.bottom,
                       got.found, got.left, got.top, got.right, got.bottom);
            err_count++;
          end
        end
      end

      if (in_valid && in_ready) begin
        w = span(width_q);
        h = span(height_q);
        if (pixel_color(fmt_q, pixel_word) != back_q) begin
          if (col_pos < left_edge) left_edge = col_pos;
          if (col_pos > right_edge) right_edge = col_pos;
          if (row_pos < top_edge) top_edge = row_pos;
          if (row_pos > bottom_edge) bottom_edge = row_pos;
          seen = 1;
        end
        // a shrunk dimension mid-frame wraps at once
        if (col_pos + 1 < w) begin
          col_pos++;
        end else begin
          col_pos = 0;
          if (row_pos + 1 < h) begin
            row_pos++;
          end else begin
            want = '0;
            if (seen) begin
              want.found = 1'b1;
              want.left = BOX_W'(left_edge);
              want.top = BOX_W'(top_edge);
              want.right = BOX_W'(right_edge);
              want.bottom = BOX_W'(bottom_edge);
            end
            box_due.push_back(want);
            clear_frame();
          end
        end
      end

      if (cfg_we) begin
        case (cfg_index)
          REG_PIXEL_FORMAT: fmt_q = cfg_data[FMT_W-1:0];
          REG_FRAME_WIDTH:  width_q = cfg_data[DIM_CFG_W-1:0];
          REG_FRAME_HEIGHT: height_q = cfg_data[DIM_CFG_W-1:0];
          REG_BACK_COLOR:   back_q = cfg_data[COLOR_W-1:0];
          default: ;
        endcase
      end
    end
    box_errors <= err_count;
    boxes_due <= box_due.size();
  end

endmodule

[sim/tb.sv]
`timescale 1ns / 100ps
// Testbench top for foreground_bounding_box: clock, reset, pixel and result
// traffic, register writes and the verdict. Depends on fgbb_pkg and fgbb_box_checker.

module tb;
  import fgbb_pkg::*;

  localparam int RANDOM_WORDS = 1600;
  localparam int SETTLE_CYCLES = 4;
  localparam int DIM_TOP = (1 << DIM_CFG_W) - 1;
  // codes past the supported formats decode to zero
  localparam logic [FMT_W-1:0] FMT_NONE_LO = 3'd4;
  localparam logic [FMT_W-1:0] FMT_NONE_HI = 3'd7;

  logic clk, rst;
  logic in_valid, in_ready, out_valid, out_ready;
  logic [PIXEL_W-1:0] pixel_word;
  logic found;
  logic [BOX_W-1:0] box_left, box_top, box_right, box_bottom;
  logic cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  int box_errors, boxes_due;
  int gap_pct, stall_pct;
  int words_sent;
  logic [FMT_W-1:0] fmt_choice[4] = '{FMT_555, FMT_565, FMT_24, FMT_32};

  foreground_bounding_box dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .pixel_word(pixel_word),
    .out_valid(out_valid), .out_ready(out_ready), .found(found),
    .box_left(box_left), .box_top(box_top), .box_right(box_right), .box_bottom(box_bottom),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  fgbb_box_checker box_check (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .pixel_word(pixel_word),
    .out_valid(out_valid), .out_ready(out_ready), .found(found),
    .box_left(box_left), .box_top(box_top), .box_right(box_right), .box_bottom(box_bottom),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .box_errors(box_errors), .boxes_due(boxes_due)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  always @(posedge clk) out_ready <= ($urandom_range(0, 99) >= stall_pct);

  initial begin
    #1_000_000;
    $display("tb: done, errors");
    $finish;
  end

  task automatic set_idling(input int stage);
    case (stage)
      0: begin gap_pct = 30; stall_pct = 77; end
      1: begin gap_pct = 77; stall_pct = 30; end
      default: begin gap_pct = 0; stall_pct = 0; end
    endcase
  endtask

  task automatic send_word(input logic [PIXEL_W-1:0] word);
    int gap;
    gap = 0;
    while (gap < 24 && $urandom_range(0, 99) < gap_pct) gap++;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    pixel_word <= word;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    words_sent++;
  endtask

  // hold the input until every due box is out and the pipe has emptied
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (boxes_due != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
  endtask

  task automatic configure(input logic [FMT_W-1:0] fmt, input int wid, input int hgt,
                           input logic [COLOR_W-1:0] back);
    drain();
    write_reg(REG_PIXEL_FORMAT, CFG_DATA_W'(fmt));
    write_reg(REG_FRAME_WIDTH, CFG_DATA_W'(wid));
    write_reg(REG_FRAME_HEIGHT, CFG_DATA_W'(hgt));
    write_reg(REG_BACK_COLOR, CFG_DATA_W'(back));
    cfg_we <= 1'b0;
  endtask

  // a word that decodes to the background where the format can express it
  function automatic logic [PIXEL_W-1:0] background_word(input logic [FMT_W-1:0] fmt,
                                                         input logic [COLOR_W-1:0] back);
    logic [PIXEL_W-1:0] w;
    w = $urandom;
    case (fmt)
      FMT_555: w[14:0] = {back[23:19], back[15:11], back[7:3]};
      FMT_565: w[15:0] = {back[23:19], back[15:10], back[7:3]};
      FMT_24, FMT_32: w[23:0] = {back[7:0], back[15:8], back[23:16]};
      default: ;
    endcase
    return w;
  endfunction

  initial begin : stimulus
    logic [FMT_W-1:0] fmt;
    logic [COLOR_W-1:0] back;
    logic [PIXEL_W-1:0] word;
    int wid, hgt, ew, eh, frame_len, count, dens, pick, base;
    rst <= 1'b1;
    in_valid <= 1'b0;
    pixel_word <= '0;
    cfg_we <= 1'b0;
    cfg_index <= REG_PIXEL_FORMAT;
    cfg_data <= '0;
    words_sent = 0;
    set_idling(0);
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // top byte ignored, three scattered foreground pixels
    configure(FMT_24, 4, 2, 24'h000000);
    send_word(32'h0000_0000); send_word(32'hFF00_0000);
    send_word(32'h00FF_FFFF); send_word(32'h0000_0000);
    send_word(32'h0000_0000); send_word(32'h0000_0100);
    send_word(32'h0000_0000); send_word(32'hFFFF_FFFF);
    // zero width acts as one; bit 15 and the upper half drop out in 555
    configure(FMT_555, 0, 2, 24'hF8F8F8);
    send_word(32'hFFFF_FFFF); send_word(32'h0000_8000);
    configure(FMT_565, 3, 1, 24'h000000);
    send_word(32'hFFFF_0000); send_word(32'h0000_FFFF); send_word(32'h0000_0000);
    // unsupported codes: nothing found on black, everything on non-black
    configure(FMT_NONE_HI, 2, 1, 24'h000000);
    send_word(32'hFFFF_FFFF); send_word(32'h1234_5678);
    configure(FMT_NONE_LO, 2, 1, 24'h000001);
    send_word(32'h0000_0000); send_word(32'hFFFF_FFFF);
    // shrink the width with the counters mid-frame
    configure(FMT_32, 2, 2, 24'hFFFFFF);
    send_word(32'hFFFF_FFFF); send_word(32'h00FF_FFFF); send_word(32'h0000_0000);
    configure(FMT_32, 1, 2, 24'hFFFFFF);
    send_word(32'h0000_0000);

    base = words_sent;
    while (words_sent - base < RANDOM_WORDS) begin
      set_idling((words_sent - base) * 3 / RANDOM_WORDS);
      pick = $urandom_range(0, 9);
      fmt = (pick < 8) ? fmt_choice[pick % 4] : FMT_W'($urandom_range(FMT_NONE_LO, FMT_NONE_HI));
      pick = $urandom_range(0, 39);
      case (pick)
        0: begin
          wid = $urandom_range(0, 1) ? MAX_DIM : $urandom_range(MAX_DIM + 1, DIM_TOP);
          hgt = $urandom_range(0, 1);
        end
        1: begin
          wid = $urandom_range(0, 1);
          hgt = $urandom_range(0, 1) ? MAX_DIM : $urandom_range(MAX_DIM + 1, DIM_TOP);
        end
        2: begin
          wid = 0;
          hgt = 0;
        end
        default: begin
          wid = $urandom_range(1, 8);
          hgt = $urandom_range(1, 8);
        end
      endcase
      pick = $urandom_range(0, 9);
      if (pick == 0) back = '0;
      else if (pick == 1) back = '1;
      else begin
        back = COLOR_W'($urandom);
        if (fmt == FMT_555) back &= 24'hF8F8F8;
        if (fmt == FMT_565) back &= 24'hF8FCF8;
      end
      configure(fmt, wid, hgt, back);

      ew = (wid == 0) ? 1 : (wid > MAX_DIM) ? MAX_DIM : wid;
      eh = (hgt == 0) ? 1 : (hgt > MAX_DIM) ? MAX_DIM : hgt;
      frame_len = ew * eh;
      count = (frame_len > 16) ? frame_len : frame_len * $urandom_range(1, 4);
      // leave a part frame now and then, so the next settings land mid-frame
      if ($urandom_range(0, 3) == 0) count += $urandom_range(0, frame_len - 1);
      pick = $urandom_range(0, 3);
      dens = (pick == 0) ? 0 : (pick == 1) ? 3 : (pick == 2) ? 25 : 100;
      repeat (count) begin
        word = ($urandom_range(0, 99) < dens) ? $urandom : background_word(fmt, back);
        send_word(word);
      end
    end

    drain();
    if (box_errors == 0 && boxes_due == 0)
      $display("tb: done, clean");
    else
      $display("tb: done, errors");
    $finish;
  end

endmodule

[foreground_bounding_box.f]
rtl/fgbb_pkg.sv
rtl/fgbb_decode.sv
rtl/fgbb_tracker.sv
rtl/foreground_bounding_box.sv
sim/fgbb_box_checker.sv
sim/tb.sv
